[rtl/core/kll_pkg.sv]
// types, keyword table and sizes shared by the keyword and literal lexer
`timescale 1ns / 1ps

package kll_pkg;

    localparam int MAX_WORD_LEN = 8;
    localparam int NUM_KEYWORDS = 5;
    localparam int KW_TABLE     = 5;
    localparam int KW_MAX_LEN   = 6;
    localparam int KW_USED      = (NUM_KEYWORDS < KW_TABLE) ? NUM_KEYWORDS : KW_TABLE;
    // word length saturates one above the stored maximum
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 2);
    localparam int KW_IDX_W     = 3;
    localparam int VALUE_W      = 32;

    localparam logic [7:0] KW_TEXT [KW_TABLE][KW_MAX_LEN] = '{
        '{"s", "a", "y", "s", 8'h00, 8'h00},
        '{"n", "u", "m", 8'h00, 8'h00, 8'h00},
        '{"d", "e", "c", 8'h00, 8'h00, 8'h00},
        '{"l", "e", "t", "t", "e", "r"},
        '{"b", "y", "e", 8'h00, 8'h00, 8'h00}
    };
    localparam int KW_LEN [KW_TABLE] = '{4, 3, 3, 6, 3};

    typedef enum logic [1:0] {
        TOK_KEYWORD   = 2'd0,
        TOK_LITERAL   = 2'd1,
        TOK_SEMICOLON = 2'd2,
        TOK_ERROR     = 2'd3
    } tok_kind_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
    } lex_in_t;

    typedef struct packed {
        tok_kind_t             token_kind;
        logic [KW_IDX_W-1:0]   keyword_index;
        logic [VALUE_W-1:0]    literal_value;
        logic                  literal_saturated;
        logic                  last_of_run;
    } lex_out_t;

endpackage

[rtl/core/keyword_literal_lexer.sv]
// keyword and integer literal lexer: byte in, tokens out through a small queue
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+----------------------------------
//   char     | char_valid   | char_stall   | char_data  (byte, end of text)
//   token    | token_valid  | token_stall  | token_data (kind, index, value)
//
// one byte is taken per cycle; its tokens (zero to two) land in a four-entry
// queue in the same cycle and leave one per cycle, so throughput is one byte
// per cycle while each byte makes at most one token, and the token port sets
// the pace otherwise. char_stall rises while fewer than two queue slots are
// free. the per-byte path is one keyword compare and one multiply-add by ten.
// rst_n clears the lexer state and empties the queue at once.
`timescale 1ns / 1ps

module keyword_literal_lexer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  kll_pkg::lex_in_t  char_data,
    output logic              token_valid,
    input  logic              token_stall,
    output kll_pkg::lex_out_t token_data
);
    import kll_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_WORD   = 2'd1,
        MODE_NUM    = 2'd2,
        MODE_SILENT = 2'd3
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [7:0]         chars_reg [MAX_WORD_LEN];
    logic [7:0]         chars_next [MAX_WORD_LEN];
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [VALUE_W-1:0] accum_reg, accum_next;
    logic               ovf_reg, ovf_next;

    lex_out_t           fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               char_accept, token_accept;
    logic [7:0]         c;
    logic               eot;
    logic               is_let, is_dig, is_alnum, is_sp, is_semi;
    logic               word_end, num_end, start_word, append, start_num, add_num;
    logic               idle_path;

    logic [7:0]         mchars [MAX_WORD_LEN];
    logic [LEN_W-1:0]   mlen;
    logic               kw_hit, kw_eq;
    logic [KW_IDX_W-1:0] kw_idx;

    logic [VALUE_W-1:0] base;
    logic [VALUE_W+3:0] sum10;
    logic               mul_ovf;

    lex_out_t           tok_a, tok_b, tok_c, res0, res1;
    logic               a_v, b_v, c_v;
    logic [1:0]         push_cnt;

    assign char_accept  = char_valid && !char_stall;
    assign token_valid  = (count_reg != '0);
    assign token_accept = token_valid && !token_stall;
    assign token_data   = fifo_reg[rd_ptr_reg];
    assign char_stall   = (count_reg > CNT_W'(FIFO_DEPTH - 2));

    assign c        = char_data.char_byte;
    assign eot      = char_data.end_of_text;
    assign is_let   = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_dig   = (c >= "0" && c <= "9");
    assign is_alnum = is_let || is_dig;
    assign is_sp    = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    assign is_semi  = (c == ";");

    assign word_end   = (mode_reg == MODE_WORD) && !is_alnum;
    assign num_end    = (mode_reg == MODE_NUM) && !is_dig;
    assign append     = (mode_reg == MODE_WORD) && is_alnum;
    assign start_word = is_let && (mode_reg == MODE_IDLE || mode_reg == MODE_NUM);
    assign start_num  = is_dig && (mode_reg == MODE_IDLE);
    assign add_num    = is_dig && (mode_reg == MODE_NUM);
    assign idle_path  = (mode_reg == MODE_IDLE) || num_end || (word_end && kw_hit);

    // word buffer after this byte
    always_comb
    begin
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            chars_next[i] = chars_reg[i];
        end
        len_next = len_reg;
        if (start_word)
        begin
            chars_next[0] = c;
            len_next      = LEN_W'(1);
        end
        else if (append)
        begin
            if (len_reg < LEN_W'(MAX_WORD_LEN))
            begin
                chars_next[len_reg[$clog2(MAX_WORD_LEN)-1:0]] = c;
            end
            if (len_reg <= LEN_W'(MAX_WORD_LEN))
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end
        else if (word_end)
        begin
            len_next = '0;
        end
    end

    // a word ending here is the stored one, a word flushed at end of text
    // already holds this byte
    always_comb
    begin
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            mchars[i] = word_end ? chars_reg[i] : chars_next[i];
        end
        mlen   = word_end ? len_reg : len_next;
        kw_hit = 1'b0;
        kw_idx = '0;
        kw_eq  = 1'b0;
        for (int k = 0; k < KW_USED; k++)
        begin
            kw_eq = (mlen == LEN_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++)
            begin
                if (i < KW_LEN[k] && mchars[i] != KW_TEXT[k][i])
                begin
                    kw_eq = 1'b0;
                end
            end
            if (kw_eq && !kw_hit)
            begin
                kw_hit = 1'b1;
                kw_idx = KW_IDX_W'(k);
            end
        end
    end

    // value * 10 + digit, saturating
    assign base    = start_num ? '0 : accum_reg;
    assign sum10   = ({4'b0, base} << 3) + ({4'b0, base} << 1) + (VALUE_W + 4)'(c[3:0]);
    assign mul_ovf = |sum10[VALUE_W+3:VALUE_W];

    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        ovf_next   = ovf_reg;
        tok_a      = '0;
        tok_b      = '0;
        tok_c      = '0;
        a_v        = 1'b0;
        b_v        = 1'b0;
        c_v        = 1'b0;

        if (start_num || add_num)
        begin
            accum_next = mul_ovf ? '1 : sum10[VALUE_W-1:0];
            ovf_next   = (start_num ? 1'b0 : ovf_reg) | mul_ovf;
        end

        if (word_end)
        begin
            a_v = 1'b1;
            if (kw_hit)
            begin
                tok_a.token_kind    = TOK_KEYWORD;
                tok_a.keyword_index = kw_idx;
                mode_next           = MODE_IDLE;
            end
            else
            begin
                tok_a.token_kind = TOK_ERROR;
                mode_next        = MODE_SILENT;
            end
        end
        else if (num_end)
        begin
            a_v                     = 1'b1;
            tok_a.token_kind        = TOK_LITERAL;
            tok_a.literal_value     = accum_reg;
            tok_a.literal_saturated = ovf_reg;
            accum_next              = '0;
            ovf_next                = 1'b0;
            mode_next               = MODE_IDLE;
        end

        if (idle_path)
        begin
            if (is_let)
            begin
                mode_next = MODE_WORD;
            end
            else if (is_dig)
            begin
                mode_next = MODE_NUM;
            end
            else if (is_semi)
            begin
                b_v              = 1'b1;
                tok_b.token_kind = TOK_SEMICOLON;
            end
            else if (!is_sp)
            begin
                b_v              = 1'b1;
                tok_b.token_kind = TOK_ERROR;
                mode_next        = MODE_SILENT;
            end
        end

        // end of text flushes a pending token and clears the mode, value and overflow flag
        if (eot)
        begin
            if (mode_next == MODE_WORD)
            begin
                c_v = 1'b1;
                if (kw_hit)
                begin
                    tok_c.token_kind    = TOK_KEYWORD;
                    tok_c.keyword_index = kw_idx;
                end
                else
                begin
                    tok_c.token_kind = TOK_ERROR;
                end
            end
            else if (mode_next == MODE_NUM)
            begin
                c_v                     = 1'b1;
                tok_c.token_kind        = TOK_LITERAL;
                tok_c.literal_value     = accum_next;
                tok_c.literal_saturated = ovf_next;
            end
            mode_next  = MODE_IDLE;
            accum_next = '0;
            ovf_next   = 1'b0;
        end
    end

    // pack up to two tokens in order
    always_comb
    begin
        res0     = a_v ? tok_a : (b_v ? tok_b : tok_c);
        res1     = (a_v && b_v) ? tok_b : tok_c;
        push_cnt = 2'(a_v) + 2'(b_v) + 2'(c_v);
        if (push_cnt == 2'd1)
        begin
            res0.last_of_run = 1'b1;
        end
        if (push_cnt == 2'd2)
        begin
            res1.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            len_reg    <= '0;
            accum_reg  <= '0;
            ovf_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (char_accept)
            begin
                mode_reg  <= mode_next;
                len_reg   <= eot ? '0 : len_next;
                accum_reg <= accum_next;
                ovf_reg   <= ovf_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            end
            if (token_accept)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(char_accept ? push_cnt : 2'd0)
                         - CNT_W'(token_accept);
        end
    end

    // word buffer and queue storage carry no reset
    always_ff @(posedge clk)
    begin
        if (char_accept)
        begin
            for (int i = 0; i < MAX_WORD_LEN; i++)
            begin
                chars_reg[i] <= chars_next[i];
            end
            if (push_cnt != 2'd0)
            begin
                fifo_reg[wr_ptr_reg] <= res0;
            end
            if (push_cnt == 2'd2)
            begin
                fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("token queue overfilled");

    a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (char_accept && eot) |=> (mode_reg == MODE_IDLE && len_reg == '0))
        else $error("end of text did not return lexer to idle");

    a_silent_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (char_accept && mode_reg == MODE_SILENT) |-> (push_cnt == 2'd0))
        else $error("token produced while silent after error");

    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        char_accept |-> (count_reg <= CNT_W'(FIFO_DEPTH - 2)))
        else $error("byte taken without room for two tokens");

endmodule
